// File: rtl/core/epia_pkg.sv
`default_nettype none

package epia_pkg;

  // defaults for the top-level parameters
  localparam int EVENT_TYPES_DEF = 16;
  localparam int MAX_RETRIES_DEF = 3;

  // pending bits examined per scan cycle
  localparam int SCAN_LANES = 4;

  // field widths
  localparam int CMD_W      = 2;
  localparam int TYPE_W     = 4;
  localparam int ID_W       = 8;
  localparam int HEV_W      = 32;
  localparam int VER_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int SRC_W      = 16;
  localparam int TICK_W     = 16;
  localparam int FAIL_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int KEY_MATRIX_TYPE = 0;
  localparam logic [VER_W-1:0]  MORE_VERSION = 2'd2;
  localparam logic [FAIL_W-1:0] FAIL_SAT     = 2'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_POST      = 2'd0,
    CMD_SEND_DONE = 2'd1,
    CMD_TICK      = 2'd2,
    CMD_QUERY     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_NOSRC = 2'd2,
    ST_NOTQ  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WAKE_MASK   = 2'd0,
    CFG_SRC_MASK    = 2'd1,
    CFG_RETRY_TICKS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    cmd_t              command;
    logic [TYPE_W-1:0] evt_kind;
    logic              send_ok;
    logic [ID_W-1:0]   send_id;
    logic              host_sleeping;
    logic [HEV_W-1:0]  host_events;
    logic [VER_W-1:0]  host_version;
  } item_t;

  typedef struct packed {
    status_t           status;
    logic [TYPE_W-1:0] chosen_event;
    logic              more_events;
    logic              raise_request;
    logic [ID_W-1:0]   raise_id;
    logic              line_release;
    logic              retry_toggled;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_is_query;
    logic scan_last;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/epia_if.sv
`default_nettype none

interface epia_req_if;
  logic                            valid;
  logic                            ready;
  logic [epia_pkg::CMD_W-1:0]      command;
  logic [epia_pkg::TYPE_W-1:0]     evt_kind;
  logic                            send_ok;
  logic [epia_pkg::ID_W-1:0]       send_id;
  logic                            host_sleeping;
  logic [epia_pkg::HEV_W-1:0]      host_events;
  logic [epia_pkg::VER_W-1:0]      host_version;

  modport source (
    output valid, command, evt_kind, send_ok, send_id, host_sleeping, host_events,
           host_version,
    input  ready
  );
  modport sink (
    input  valid, command, evt_kind, send_ok, send_id, host_sleeping, host_events,
           host_version,
    output ready
  );
endinterface

interface epia_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [epia_pkg::STATUS_W-1:0]   status;
  logic [epia_pkg::TYPE_W-1:0]     chosen_event;
  logic                            more_events;
  logic                            raise_request;
  logic [epia_pkg::ID_W-1:0]       raise_id;
  logic                            line_release;
  logic                            retry_toggled;

  modport source (
    output valid, status, chosen_event, more_events, raise_request, raise_id, line_release,
           retry_toggled,
    input  ready
  );
  modport sink (
    input  valid, status, chosen_event, more_events, raise_request, raise_id, line_release,
           retry_toggled,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/core/epia_ctrl.sv
`default_nettype none

module epia_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_ready,
  output epia_pkg::dp_cmd_t       cmd,
  input  wire epia_pkg::dp_stat_t stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state;
  logic   accept;

  assign req_ready     = (state == S_IDLE);
  assign accept        = req_valid && req_ready;
  assign cmd.capture   = accept;
  assign cmd.scan_step = (state == S_SCAN);
  // result slot is free when empty or being drained this cycle
  assign cmd.commit    = (state == S_COMMIT) && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= stat.in_is_query ? S_SCAN : S_COMMIT;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      rsp_valid <= cmd.commit || (rsp_valid && !rsp_ready);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/epia_dp.sv
`default_nettype none

module epia_dp #(
  parameter int EVENT_TYPES = epia_pkg::EVENT_TYPES_DEF,
  parameter int MAX_RETRIES = epia_pkg::MAX_RETRIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [epia_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [epia_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire epia_pkg::item_t                    item,
  input  wire epia_pkg::dp_cmd_t                  cmd,
  output epia_pkg::dp_stat_t                      stat,
  output epia_pkg::result_t                       result
);

  localparam int TW    = $clog2(EVENT_TYPES);
  localparam int LANES = epia_pkg::SCAN_LANES;
  localparam int OW    = $clog2(EVENT_TYPES + LANES);
  localparam int SW    = OW + 1;
  localparam int OUT_TW = epia_pkg::TYPE_W;
  localparam int NSRC  = epia_pkg::SRC_W;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_RAISING  = 2'd1,
    PH_ACTIVE   = 2'd2
  } phase_t;

  // configuration
  logic [epia_pkg::HEV_W-1:0]  wake_mask;
  logic [epia_pkg::SRC_W-1:0]  source_present_mask;
  logic [epia_pkg::TICK_W-1:0] retry_ticks;

  // arbiter state
  logic [EVENT_TYPES-1:0]        pending_events, pending_events_next;
  phase_t                        irq_phase, irq_phase_next;
  logic [epia_pkg::ID_W-1:0]     raise_counter, raise_counter_next;
  logic [epia_pkg::FAIL_W-1:0]   failed_count, failed_count_next;
  logic [TW-1:0]                 rr_start, rr_start_next;
  logic [epia_pkg::TICK_W-1:0]   retry_countdown, retry_countdown_next;
  logic                          retry_armed, retry_armed_next;

  // captured request and scan
  epia_pkg::item_t               item_q;
  logic [OW-1:0]                 scan_off;
  logic                          found;
  logic [TW-1:0]                 found_idx;
  logic [TW-1:0]                 lane_idx [LANES];
  logic [LANES-1:0]              lane_hit;
  logic                          step_hit;
  logic [TW-1:0]                 step_idx;

  epia_pkg::result_t             res_next;
  logic                          do_raise;
  logic [EVENT_TYPES-1:0]        post_vec, take_vec;
  logic                          src_ok;
  logic [epia_pkg::TICK_W-1:0]   ticks_load;

  function automatic logic raise_ok(
    input logic [EVENT_TYPES-1:0]      pend,
    input phase_t                      ph,
    input logic                        sleeping,
    input logic [epia_pkg::HEV_W-1:0]  hev,
    input logic [epia_pkg::HEV_W-1:0]  wmask
  );
    logic skip;
    skip = sleeping && ((hev & wmask) == '0) && !pend[epia_pkg::KEY_MATRIX_TYPE];
    return (pend != '0) && (ph == PH_INACTIVE) && !skip;
  endfunction

  assign stat.in_is_query = (item.command == epia_pkg::CMD_QUERY);

  // round-robin scan, a group of lanes per cycle
  always_comb begin
    logic [SW-1:0] off;
    logic [SW-1:0] sum;
    for (int j = 0; j < LANES; j++) begin
      off = SW'(scan_off) + SW'(j);
      sum = SW'(rr_start) + off;
      if (sum >= SW'(EVENT_TYPES)) begin
        sum = sum - SW'(EVENT_TYPES);
      end
      lane_idx[j] = sum[TW-1:0];
      lane_hit[j] = (off < SW'(EVENT_TYPES)) && pending_events[sum[TW-1:0]];
    end
  end

  always_comb begin
    step_hit = 1'b0;
    step_idx = '0;
    for (int j = LANES - 1; j >= 0; j--) begin
      if (lane_hit[j]) begin
        step_hit = 1'b1;
        step_idx = lane_idx[j];
      end
    end
  end

  assign stat.scan_last = step_hit || ((SW'(scan_off) + SW'(LANES)) >= SW'(EVENT_TYPES));

  // one-hot vectors for set, clear and source lookup
  always_comb begin
    src_ok = 1'b0;
    for (int t = 0; t < EVENT_TYPES; t++) begin
      post_vec[t] = (int'(item_q.evt_kind) == t);
      take_vec[t] = (int'(found_idx) == t);
    end
    for (int t = 0; t < NSRC; t++) begin
      if (int'(found_idx) == t) begin
        src_ok = source_present_mask[t];
      end
    end
  end

  assign ticks_load = (retry_ticks == '0) ? epia_pkg::TICK_W'(1) : retry_ticks;

  // next state and result of the captured request
  always_comb begin
    pending_events_next  = pending_events;
    irq_phase_next       = irq_phase;
    raise_counter_next   = raise_counter;
    failed_count_next    = failed_count;
    rr_start_next        = rr_start;
    retry_countdown_next = retry_countdown;
    retry_armed_next     = retry_armed;
    res_next             = '0;
    res_next.status      = epia_pkg::ST_NOTQ;
    do_raise             = 1'b0;

    case (item_q.command)
      epia_pkg::CMD_POST: begin
        pending_events_next = pending_events | post_vec;
        do_raise = raise_ok(pending_events_next, irq_phase, item_q.host_sleeping,
                            item_q.host_events, wake_mask);
      end
      epia_pkg::CMD_SEND_DONE: begin
        if (irq_phase == PH_RAISING && item_q.send_id == raise_counter) begin
          irq_phase_next       = item_q.send_ok ? PH_ACTIVE : PH_INACTIVE;
          retry_countdown_next = ticks_load;
          retry_armed_next     = 1'b1;
        end
      end
      epia_pkg::CMD_TICK: begin
        if (retry_armed) begin
          retry_countdown_next = retry_countdown - 1'b1;
          if (retry_countdown_next == '0) begin
            retry_armed_next = 1'b0;
            if (irq_phase == PH_ACTIVE) begin
              if (failed_count != epia_pkg::FAIL_SAT) begin
                failed_count_next = failed_count + 1'b1;
              end
              if (int'(failed_count_next) < MAX_RETRIES) begin
                irq_phase_next         = PH_INACTIVE;
                res_next.retry_toggled = 1'b1;
              end
            end
            do_raise = raise_ok(pending_events, irq_phase_next, item_q.host_sleeping,
                                item_q.host_events, wake_mask);
          end
        end
      end
      epia_pkg::CMD_QUERY: begin
        if (!found) begin
          irq_phase_next        = PH_INACTIVE;
          failed_count_next     = '0;
          retry_armed_next      = 1'b0;
          retry_countdown_next  = '0;
          res_next.line_release = 1'b1;
          res_next.status       = epia_pkg::ST_NONE;
        end else begin
          pending_events_next   = pending_events & ~take_vec;
          rr_start_next         = (int'(found_idx) + 1 >= EVENT_TYPES) ? '0
                                                                       : found_idx + 1'b1;
          res_next.chosen_event = OUT_TW'(found_idx);
          if (!src_ok) begin
            res_next.status = epia_pkg::ST_NOSRC;
          end else begin
            res_next.status = epia_pkg::ST_OK;
            if (pending_events_next == '0) begin
              irq_phase_next        = PH_INACTIVE;
              failed_count_next     = '0;
              retry_armed_next      = 1'b0;
              retry_countdown_next  = '0;
              res_next.line_release = 1'b1;
            end else if (item_q.host_version >= epia_pkg::MORE_VERSION) begin
              res_next.more_events = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase

    if (do_raise) begin
      irq_phase_next         = PH_RAISING;
      raise_counter_next     = raise_counter + 1'b1;
      res_next.raise_request = 1'b1;
      res_next.raise_id      = raise_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wake_mask           <= '1;
      source_present_mask <= '1;
      retry_ticks         <= epia_pkg::TICK_W'(1000);
    end else if (cfg_we) begin
      case (epia_pkg::cfg_idx_t'(cfg_index))
        epia_pkg::CFG_WAKE_MASK:   wake_mask <= cfg_data;
        epia_pkg::CFG_SRC_MASK:    source_present_mask <= cfg_data[epia_pkg::SRC_W-1:0];
        epia_pkg::CFG_RETRY_TICKS: retry_ticks <= cfg_data[epia_pkg::TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_events  <= '0;
      irq_phase       <= PH_INACTIVE;
      raise_counter   <= '0;
      failed_count    <= '0;
      rr_start        <= '0;
      retry_countdown <= '0;
      retry_armed     <= 1'b0;
      found           <= 1'b0;
    end else begin
      if (cmd.capture) begin
        found <= 1'b0;
      end else if (cmd.scan_step && step_hit) begin
        found <= 1'b1;
      end
      if (cmd.commit) begin
        pending_events  <= pending_events_next;
        irq_phase       <= irq_phase_next;
        raise_counter   <= raise_counter_next;
        failed_count    <= failed_count_next;
        rr_start        <= rr_start_next;
        retry_countdown <= retry_countdown_next;
        retry_armed     <= retry_armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q   <= item;
      scan_off <= '0;
    end else if (cmd.scan_step) begin
      scan_off <= scan_off + OW'(LANES);
      if (step_hit) begin
        found_idx <= step_idx;
      end
    end
    if (cmd.commit) begin
      result <= res_next;
    end
  end

  a_armed_nonzero: assert property (@(posedge clk) disable iff (rst)
    retry_armed |-> retry_countdown != '0)
    else $error("retry timer armed with zero count");

  a_raise_id: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && do_raise |=> raise_counter == result.raise_id && irq_phase == PH_RAISING)
    else $error("raise id does not match raise counter");

  a_take_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && item_q.command == epia_pkg::CMD_QUERY && found
    |=> !pending_events[$past(found_idx)])
    else $error("taken event still pending");

endmodule

`default_nettype wire

// File: rtl/core/event_pending_interrupt_arbiter_unit.sv
`default_nettype none

// event pending interrupt arbiter: keeps a bitmap of pending event types and a host
// interrupt that moves through inactive, raising and active. every request on req
// (post event, send done, tick, get next event) yields exactly one result on rsp.
// a post, send done or tick passes through capture and then commit to reach its result;
// a get-next query has scan steps between capture and commit, since the round-robin
// scanner looks at four pending bits per cycle starting at the rotating start pointer
// and stops at the first group holding a pending bit (or at the last group when nothing
// is pending). one request is in work at a time; req is ready again in the cycle after
// the commit, and a finished result waits in the output register while the next
// request is taken in. the commit stalls only if the previous result is still
// unclaimed.
// configuration writes (cfg_we, cfg_index, cfg_data) take effect at once and belong
// in idle periods; index 0 wake mask, 1 source present mask, 2 retry ticks.
module event_pending_interrupt_arbiter_unit #(
  parameter int EVENT_TYPES = epia_pkg::EVENT_TYPES_DEF,
  parameter int MAX_RETRIES = epia_pkg::MAX_RETRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [epia_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [epia_pkg::CFG_DATA_W-1:0]  cfg_data,
  epia_req_if.sink                              req,
  epia_rsp_if.source                            rsp
);

  epia_pkg::item_t    item;
  epia_pkg::result_t  result;
  epia_pkg::dp_cmd_t  cmd;
  epia_pkg::dp_stat_t stat;

  // request payload into one packed item
  assign item.command       = epia_pkg::cmd_t'(req.command);
  assign item.evt_kind      = req.evt_kind;
  assign item.send_ok       = req.send_ok;
  assign item.send_id       = req.send_id;
  assign item.host_sleeping = req.host_sleeping;
  assign item.host_events   = req.host_events;
  assign item.host_version  = req.host_version;

  // sequencing of capture, scan and commit
  epia_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // bitmap, interrupt phase, retry timer and scanner
  epia_dp #(
    .EVENT_TYPES (EVENT_TYPES),
    .MAX_RETRIES (MAX_RETRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .stat      (stat),
    .result    (result)
  );

  // registered result onto the response channel
  assign rsp.status        = result.status;
  assign rsp.chosen_event  = result.chosen_event;
  assign rsp.more_events   = result.more_events;
  assign rsp.raise_request = result.raise_request;
  assign rsp.raise_id      = result.raise_id;
  assign rsp.line_release  = result.line_release;
  assign rsp.retry_toggled = result.retry_toggled;

endmodule

`default_nettype wire
